FILE: rtl/chroma_dc_2x2_hadamard_quant_defines.svh
// Assertion macros shared by the chroma DC transform and quantizer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef CHROMA_DC_2X2_HADAMARD_QUANT_DEFINES_SVH
`define CHROMA_DC_2X2_HADAMARD_QUANT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition holds in the same cycle as the trigger.
`define CHDQ_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error("assertion failed: same-cycle check");

// Condition holds in the cycle after the trigger.
`define CHDQ_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("assertion failed: next-cycle check");

`else

`define CHDQ_ASSERT_SAME(label, clk, rst_n, trig, cond)
`define CHDQ_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

FILE: rtl/chdq_pkg.sv
// Package for the chroma DC 2x2 Hadamard transform and quantizer.
// Holds beat types, mode codes, lane control struct and constant tables.
// No dependencies.
package chdq_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int WIDE_W    = 18;  // Hadamard sums of four 16-bit values
    localparam int QE_W      = 4;   // qp / 6, up to 10
    localparam int QM_W      = 3;   // qp mod 6
    localparam int QP_W      = 6;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;
    localparam int NORM_W    = 14;
    localparam int PROD_W    = WIDE_W + NORM_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int QSH_BASE  = 16;
    localparam int QMAG_W    = SUM_W - QSH_BASE;
    localparam int LANES     = 4;

    // Mode register codes.
    localparam logic [MODE_W-1:0] MODE_BOTH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_XFORM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUANT  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QP   = 2'd1;

    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_0;
        logic signed [SAMPLE_W-1:0] sample_1;
        logic signed [SAMPLE_W-1:0] sample_2;
        logic signed [SAMPLE_W-1:0] sample_3;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] coeff_0;
        logic signed [SAMPLE_W-1:0] coeff_1;
        logic signed [SAMPLE_W-1:0] coeff_2;
        logic signed [SAMPLE_W-1:0] coeff_3;
        logic                       overflow;
    } t_out_beat;

    // Quantizer settings that every lane sees.
    typedef struct packed {
        logic            quant;
        logic [QE_W-1:0] qe;
        logic [QM_W-1:0] qm;
    } t_lane_ctrl;

    typedef struct packed {
        logic [QE_W-1:0] qe;
        logic [QM_W-1:0] qm;
    } t_qp_split;

    // Split qp into qp / 6 and qp mod 6 with a row of compares.
    function automatic t_qp_split qp_split(input logic [QP_W-1:0] qp);
        t_qp_split       res;
        logic [QE_W-1:0] qe;
        qe = '0;
        for (int k = 1; k <= 10; k++) begin
            if (int'(qp) >= 6 * k) begin
                qe = QE_W'(k);
            end
        end
        res.qe = qe;
        res.qm = QM_W'(int'(qp) - 6 * int'(qe));
        return res;
    endfunction

    // Norm factor by qp mod 6.
    function automatic logic [NORM_W-1:0] norm_of(input logic [QM_W-1:0] qm);
        logic [NORM_W-1:0] n;
        case (qm)
            3'd0:    n = 14'd13107;
            3'd1:    n = 14'd11916;
            3'd2:    n = 14'd10082;
            3'd3:    n = 14'd9362;
            3'd4:    n = 14'd8192;
            3'd5:    n = 14'd7282;
            default: n = '0;
        endcase
        return n;
    endfunction

    // Rounding offset 2*floor(2^(15+qe)/3) by qp / 6.
    function automatic logic [SUM_W-1:0] offset_of(input logic [QE_W-1:0] qe);
        logic [SUM_W-1:0] o;
        case (qe)
            4'd0:    o = 33'd21844;
            4'd1:    o = 33'd43690;
            4'd2:    o = 33'd87380;
            4'd3:    o = 33'd174762;
            4'd4:    o = 33'd349524;
            4'd5:    o = 33'd699050;
            4'd6:    o = 33'd1398100;
            4'd7:    o = 33'd2796202;
            4'd8:    o = 33'd5592404;
            4'd9:    o = 33'd11184810;
            4'd10:   o = 33'd22369620;
            default: o = '0;
        endcase
        return o;
    endfunction

endpackage

FILE: rtl/chdq_hadamard.sv
// First stage: registers the 2x2 Hadamard butterflies, or the raw
// samples sign-extended when the transform is bypassed. Uses chdq_pkg.
module chdq_hadamard
    import chdq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_transform,
    input  t_in_beat  i_block,
    output logic      o_valid,
    output t_wide     o_val [LANES]
);

    t_wide w_s [LANES];
    t_wide w_a, w_b, w_c, w_d;
    t_wide n_val [LANES];
    logic  r_valid;
    t_wide r_val [LANES];

    // Sign-extend the samples.
    always_comb begin
        w_s[0] = t_wide'(i_block.sample_0);
        w_s[1] = t_wide'(i_block.sample_1);
        w_s[2] = t_wide'(i_block.sample_2);
        w_s[3] = t_wide'(i_block.sample_3);
    end

    // Row butterflies, then column butterflies.
    always_comb begin
        w_a = w_s[0] + w_s[1];
        w_b = w_s[2] + w_s[3];
        w_c = w_s[0] - w_s[1];
        w_d = w_s[2] - w_s[3];
        if (i_transform) begin
            n_val[0] = w_a + w_b;
            n_val[1] = w_c + w_d;
            n_val[2] = w_a - w_b;
            n_val[3] = w_c - w_d;
        end else begin
            n_val = w_s;
        end
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_valid = r_valid;
    assign o_val   = r_val;

endmodule

FILE: rtl/chdq_lane.sv
// One quantizer lane: magnitude times norm factor into a register, then
// rounding, shift, sign restore and 16-bit truncation. Uses chdq_pkg.
module chdq_lane
    import chdq_pkg::*;
(
    input  logic                       i_clk,
    input  t_wide                      i_val,
    input  t_lane_ctrl                 i_ctrl,
    output logic signed [SAMPLE_W-1:0] o_coeff,
    output logic                       o_ovf
);

    logic              w_neg;
    logic [WIDE_W-1:0] w_mag;
    logic [PROD_W-1:0] n_prod;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg;
    logic              r_quant;
    logic [QE_W-1:0]   r_qe;
    t_wide             r_raw;
    logic [SUM_W-1:0]  w_sum;
    logic [QMAG_W-1:0] w_q;
    t_wide             w_qs;
    t_wide             w_res;

    // Magnitude times norm factor; the product is registered.
    always_comb begin
        w_neg  = i_val[WIDE_W-1];
        w_mag  = w_neg ? WIDE_W'(-i_val) : WIDE_W'(i_val);
        n_prod = PROD_W'(w_mag) * PROD_W'(norm_of(i_ctrl.qm));
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_neg   <= w_neg;
        r_quant <= i_ctrl.quant;
        r_qe    <= i_ctrl.qe;
        r_raw   <= i_val;
    end

    // Round, shift by 16 + qp/6, restore the sign and pick the result.
    always_comb begin
        w_sum = SUM_W'(r_prod) + offset_of(r_qe);
        w_q   = QMAG_W'(w_sum[SUM_W-1:QSH_BASE] >> r_qe);
        w_qs  = r_neg ? -t_wide'({1'b0, w_q}) : t_wide'({1'b0, w_q});
        w_res = r_quant ? w_qs : r_raw;
    end

    // Truncation loses bits unless the top bits are all sign copies.
    assign o_coeff = w_res[SAMPLE_W-1:0];
    assign o_ovf   = !((w_res[WIDE_W-1:SAMPLE_W-1] == '0) ||
                       (w_res[WIDE_W-1:SAMPLE_W-1] == '1));

endmodule

FILE: rtl/chroma_dc_2x2_hadamard_quant.sv
// Top level of the chroma DC 2x2 Hadamard transform and quantizer.
// Uses chdq_pkg, chdq_hadamard, chdq_lane and the assertion macro header.
//
//   channel   ports                              beat
//   input     start, busy, i_block               one 2x2 block of samples
//   result    o_strobe, o_result                 four coefficients, overflow
//   config    i_cfg_we, i_cfg_idx, i_cfg_data    one register write
//
// An item is taken every cycle; busy stays low. The result passes the
// butterfly register, the lane product register and the output
// register. There are four lanes, each with one multiplier.
// Synchronous active-low reset clears the valid pipeline and sets mode 0,
// qp 1. The receiver cannot stall; o_strobe marks each result for one cycle.
`include "chroma_dc_2x2_hadamard_quant_defines.svh"

module chroma_dc_2x2_hadamard_quant
    import chdq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_beat             i_block,
    output logic                 o_strobe,
    output t_out_beat            o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic [MODE_W-1:0]      r_mode;
    logic [QE_W-1:0]        r_qe;
    logic [QM_W-1:0]        r_qm;
    t_qp_split              w_split;
    logic                   w_accept;
    logic                   w_transform;
    t_lane_ctrl             w_ctrl;
    logic                   w_v1;
    t_wide                  w_val [LANES];
    logic                   r_v2;
    logic signed [SAMPLE_W-1:0] w_coeff [LANES];
    logic [LANES-1:0]       w_ovf;
    logic                   r_strobe;
    t_out_beat              n_result;
    t_out_beat              r_result;

    // The pipeline never blocks.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Configuration registers; qp is kept split into qp/6 and qp mod 6.
    assign w_split = qp_split(i_cfg_data[QP_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BOTH;
            r_qe   <= '0;
            r_qm   <= QM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                CFG_QP: begin
                    r_qe <= w_split.qe;
                    r_qm <= w_split.qm;
                end
                default: ;
            endcase
        end
    end

    // Mode 3 acts as transform only.
    always_comb begin
        w_transform  = (r_mode != MODE_QUANT);
        w_ctrl.quant = (r_mode == MODE_BOTH) || (r_mode == MODE_QUANT);
        w_ctrl.qe    = r_qe;
        w_ctrl.qm    = r_qm;
    end

    // Butterfly stage.
    chdq_hadamard u_hadamard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_transform (w_transform),
        .i_block     (i_block),
        .o_valid     (w_v1),
        .o_val       (w_val)
    );

    // Four quantizer lanes side by side.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        chdq_lane u_lane (
            .i_clk   (i_clk),
            .i_val   (w_val[g]),
            .i_ctrl  (w_ctrl),
            .o_coeff (w_coeff[g]),
            .o_ovf   (w_ovf[g])
        );
    end

    // Merge the lanes into one result beat.
    always_comb begin
        n_result.coeff_0  = w_coeff[0];
        n_result.coeff_1  = w_coeff[1];
        n_result.coeff_2  = w_coeff[2];
        n_result.coeff_3  = w_coeff[3];
        n_result.overflow = |w_ovf;
    end

    // Valid pipeline for the lane and output stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v2     <= w_v1;
            r_strobe <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Every beat leaving the lanes is presented in the next cycle.
    `CHDQ_ASSERT_NEXT(a_strobe_follows, i_clk, i_rst_n, r_v2, o_strobe)
    // A result beat always comes from an accepted item, through the butterfly, lane product and output registers.
    `CHDQ_ASSERT_SAME(a_strobe_source, i_clk, i_rst_n, o_strobe, $past(w_accept, 3))
    // A quantized magnitude stays well below 2^15, so quantizing modes never overflow.
    `CHDQ_ASSERT_SAME(a_quant_fits, i_clk, i_rst_n, o_strobe && w_ctrl.quant, !o_result.overflow)

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the chroma DC 2x2 Hadamard transform and quantizer.
// Depends on chdq_pkg and chroma_dc_2x2_hadamard_quant; it reads no files.
// Directed table first, then random blocks over mode and qp settings.
`timescale 1ns / 100ps

module tb_top
    import chdq_pkg::*;
();

    // Codes the package does not name: the alias mode and the unused indexes.
    localparam logic [MODE_W-1:0]    MODE_ALIAS   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3  = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

    // One row of the directed table. When known is set, want is the typed result.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [QP_W-1:0]   qp;
        t_in_beat          blk;
        logic              known;
        t_out_beat         want;
    } t_vec;

    localparam int N_DIRECTED = 22;
    localparam t_vec DIRECTED_VECS [N_DIRECTED] = '{
        '{MODE_BOTH,  6'd1,  '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
        '{MODE_BOTH,  6'd1,  '{16'sd1, 16'sd2, 16'sd3, 16'sd4}, 1'b0, '0},
        '{MODE_BOTH,  6'd1,  '{S_MAX, S_MAX, S_MAX, S_MAX}, 1'b0, '0},
        '{MODE_BOTH,  6'd1,  '{S_MIN, S_MIN, S_MIN, S_MIN}, 1'b0, '0},
        '{MODE_XFORM, 6'd1,  '{16'sd1, 16'sd2, 16'sd3, 16'sd4}, 1'b1,
          '{16'sd10, -16'sd2, -16'sd4, 16'sd0, 1'b0}},
        '{MODE_XFORM, 6'd1,  '{S_MAX, S_MAX, S_MAX, S_MAX}, 1'b1,
          '{-16'sd4, 16'sd0, 16'sd0, 16'sd0, 1'b1}},
        '{MODE_XFORM, 6'd1,  '{S_MIN, S_MIN, S_MIN, S_MIN}, 1'b1,
          '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}},
        '{MODE_XFORM, 6'd1,  '{S_MAX, S_MIN, S_MIN, S_MAX}, 1'b1,
          '{-16'sd2, 16'sd0, 16'sd0, -16'sd2, 1'b1}},
        '{MODE_ALIAS, 6'd1,  '{16'sd1, 16'sd2, 16'sd3, 16'sd4}, 1'b1,
          '{16'sd10, -16'sd2, -16'sd4, 16'sd0, 1'b0}},
        '{MODE_ALIAS, 6'd1,  '{S_MIN, S_MIN, S_MIN, S_MIN}, 1'b1,
          '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}},
        '{MODE_QUANT, 6'd0,  '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
        '{MODE_QUANT, 6'd0,  '{S_MAX, S_MIN, 16'sd1, -16'sd1}, 1'b0, '0},
        '{MODE_QUANT, 6'd51, '{S_MAX, S_MIN, 16'sd1, -16'sd1}, 1'b0, '0},
        '{MODE_QUANT, 6'd63, '{S_MAX, S_MIN, 16'sd1, -16'sd1}, 1'b0, '0},
        '{MODE_QUANT, 6'd52, '{S_MAX, S_MIN, 16'sd100, -16'sd100}, 1'b0, '0},
        '{MODE_BOTH,  6'd0,  '{S_MAX, S_MAX, S_MAX, S_MAX}, 1'b0, '0},
        '{MODE_BOTH,  6'd0,  '{S_MAX, S_MIN, S_MIN, S_MAX}, 1'b0, '0},
        '{MODE_BOTH,  6'd63, '{S_MIN, S_MIN, S_MIN, S_MIN}, 1'b0, '0},
        '{MODE_BOTH,  6'd51, '{-16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b0, '0},
        '{MODE_BOTH,  6'd5,  '{16'sd7, -16'sd3, 16'sd100, -16'sd250}, 1'b0, '0},
        '{MODE_QUANT, 6'd17, '{16'sd3, -16'sd3, 16'sd6, -16'sd6}, 1'b0, '0},
        '{MODE_XFORM, 6'd17, '{S_MIN, S_MAX, 16'sd0, -16'sd1}, 1'b0, '0}
    };

    localparam int N_PHASES       = 12;
    localparam int BLOCKS_PER_PHASE = 140;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    t_in_beat             i_block    = '0;
    logic                 o_strobe;
    t_out_beat            o_result;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_MODE;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    // Bench copy of the two registers, as the block should hold them.
    logic [MODE_W-1:0] mode_setting = MODE_BOTH;
    logic [QP_W-1:0]   qp_setting   = 6'd1;

    t_out_beat coeffs_due[$];
    int        blocks_sent  = 0;
    int        results_seen = 0;
    int        mismatches   = 0;

    chroma_dc_2x2_hadamard_quant dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_block    (i_block),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Quantize one value on its magnitude and put the sign back.
    function automatic longint quantise_coeff(input longint x, input logic [QP_W-1:0] qp);
        int unsigned qe;
        int unsigned qm;
        longint      norm;
        longint      off;
        longint      mag;
        longint      q;
        qe = qp / 6;
        qm = qp % 6;
        case (qm)
            0:       norm = 13107;
            1:       norm = 11916;
            2:       norm = 10082;
            3:       norm = 9362;
            4:       norm = 8192;
            default: norm = 7282;
        endcase
        off = 2 * ((longint'(1) << (15 + qe)) / 3);
        mag = (x < 0) ? -x : x;
        q = (mag * norm + off) >>> (16 + qe);
        return (x < 0) ? -q : q;
    endfunction

    // Expected coefficients and overflow flag for one block.
    function automatic t_out_beat predict_coeffs(input t_in_beat blk,
                                                 input logic [MODE_W-1:0] mode,
                                                 input logic [QP_W-1:0] qp);
        longint    s [4];
        longint    r [4];
        longint    a, b, c, d;
        t_out_beat res;
        s[0] = blk.sample_0;
        s[1] = blk.sample_1;
        s[2] = blk.sample_2;
        s[3] = blk.sample_3;
        if (mode == MODE_QUANT) begin
            for (int i = 0; i < 4; i++) r[i] = quantise_coeff(s[i], qp);
        end else begin
            a = s[0] + s[1];
            c = s[0] - s[1];
            b = s[2] + s[3];
            d = s[2] - s[3];
            r[0] = a + b;
            r[1] = c + d;
            r[2] = a - b;
            r[3] = c - d;
            if (mode == MODE_BOTH) begin
                for (int i = 0; i < 4; i++) r[i] = quantise_coeff(r[i], qp);
            end
        end
        res.overflow = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (r[i] < -32768 || r[i] > 32767) res.overflow = 1'b1;
        end
        res.coeff_0 = 16'(r[0]);
        res.coeff_1 = 16'(r[1]);
        res.coeff_2 = 16'(r[2]);
        res.coeff_3 = 16'(r[3]);
        return res;
    endfunction

    // Sample values weighted toward the extremes and small magnitudes.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = S_MIN;
            1:       v = S_MAX;
            2, 3:    v = $signed(16'($urandom_range(0, 200))) - 16'sd100;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // Offer one block beat; it is taken at the first edge with busy low.
    // Start is left high so back-to-back beats need no second assignment.
    task automatic send_block(input t_in_beat blk, input logic known,
                              input t_out_beat want);
        i_block <= blk;
        start   <= 1'b1;
        do @(posedge i_clk); while (busy);
        coeffs_due.push_back(known ? want : predict_coeffs(blk, mode_setting, qp_setting));
        blocks_sent++;
    endtask

    // Write one register once the pipeline has emptied.
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DAT_W-1:0] data);
        start <= 1'b0;
        while (coeffs_due.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE: mode_setting = data[MODE_W-1:0];
            CFG_QP:   qp_setting   = data;
            default: ;
        endcase
    endtask

    // Result checker: every strobe must match the oldest expected beat.
    always @(posedge i_clk) begin
        t_out_beat               want;
        logic signed [SAMPLE_W-1:0] exp_c [4];
        logic signed [SAMPLE_W-1:0] got_c [4];
        if (i_rst_n && o_strobe) begin
            if (coeffs_due.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %h", $time, o_result);
                mismatches++;
            end else begin
                want = coeffs_due.pop_front();
                results_seen++;
                exp_c = '{want.coeff_0, want.coeff_1, want.coeff_2, want.coeff_3};
                got_c = '{o_result.coeff_0, o_result.coeff_1,
                          o_result.coeff_2, o_result.coeff_3};
                for (int i = 0; i < 4; i++) begin
                    if (got_c[i] !== exp_c[i]) begin
                        $display("%0t: coeff_%0d expected %0d, got %0d",
                                 $time, i, exp_c[i], got_c[i]);
                        mismatches++;
                    end
                end
                if (o_result.overflow !== want.overflow) begin
                    $display("%0t: overflow expected %b, got %b",
                             $time, want.overflow, o_result.overflow);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases.
    initial begin
        logic [MODE_W-1:0] mode_cycle [4];
        logic [QP_W-1:0]   qp_edge [4];
        logic [MODE_W-1:0] mode_pick;
        logic [QP_W-1:0]   qp_pick;
        int                idle_pct;
        int                gap;
        t_in_beat          blk;

        mode_cycle = '{MODE_BOTH, MODE_XFORM, MODE_QUANT, MODE_ALIAS};
        qp_edge    = '{6'd0, 6'd63, 6'd51, 6'd52};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Writes to the unused indexes must leave mode 0, qp 1 in place.
        program_reg(CFG_SPARE_2, 6'h3E);
        program_reg(CFG_SPARE_3, 6'h3F);

        for (int n = 0; n < N_DIRECTED; n++) begin
            if (DIRECTED_VECS[n].mode != mode_setting) begin
                program_reg(CFG_MODE, {4'($urandom), DIRECTED_VECS[n].mode});
            end
            if (DIRECTED_VECS[n].qp != qp_setting) begin
                program_reg(CFG_QP, DIRECTED_VECS[n].qp);
            end
            send_block(DIRECTED_VECS[n].blk, DIRECTED_VECS[n].known, DIRECTED_VECS[n].want);
        end

        // Early phases pair each mode with a qp edge value (0, 63, 51, 52); later ones are random.
        for (int p = 0; p < N_PHASES; p++) begin
            if (p < 8) begin
                mode_pick = mode_cycle[p % 4];
                qp_pick   = qp_edge[(p / 2) % 4];
            end else begin
                mode_pick = mode_cycle[$urandom_range(0, 3)];
                qp_pick   = 6'($urandom_range(0, 63));
            end
            if ($urandom_range(0, 2) == 0) begin
                program_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, 6'($urandom));
            end
            program_reg(CFG_MODE, {4'($urandom), mode_pick});
            program_reg(CFG_QP, qp_pick);

            case (p % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 49;
                default: idle_pct = 14;
            endcase

            for (int k = 0; k < BLOCKS_PER_PHASE; k++) begin
                gap = 0;
                while ($urandom_range(0, 99) < idle_pct) gap++;
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                blk.sample_0 = pick_sample();
                blk.sample_1 = pick_sample();
                blk.sample_2 = pick_sample();
                blk.sample_3 = pick_sample();
                send_block(blk, 1'b0, '0);
                // Now and then hold off until the pipeline has drained.
                if (idle_pct == 14 && $urandom_range(0, 39) == 0) begin
                    start <= 1'b0;
                    while (coeffs_due.size() != 0) @(posedge i_clk);
                end
            end
        end

        start <= 1'b0;
        while (coeffs_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("tb_top: %0d blocks driven, %0d result beats checked", blocks_sent,
                 results_seen);
        $display("tb_top: covered all four mode codes, qp 0 to 63, spare index writes");
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog well past the slowest legal run.
    initial begin
        #2000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: chroma_dc_2x2_hadamard_quant.f
+incdir+rtl
rtl/chdq_pkg.sv
rtl/chdq_hadamard.sv
rtl/chdq_lane.sv
rtl/chroma_dc_2x2_hadamard_quant.sv
bench/tb_top.sv
